FILE: src/assert_macros.svh
// Assertion macros shared by the queue RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop on every clock edge outside reset
`define SPQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("spq assertion failed");

// check prop on every clock edge, reset included
`define SPQ_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("spq assertion failed");

`endif

FILE: src/spq_pkg.sv
// Types and constants of the sorted priority queue
package spq_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int HANDLE_W     = 16;
   localparam int KEY_W        = 32;
   localparam int COUNT_W      = 5;

   localparam logic [1:0] KIND_PUSH       = 2'd0;
   localparam logic [1:0] KIND_POP_SECOND = 2'd1;
   localparam logic [1:0] KIND_POP_FRONT  = 2'd2;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [KEY_W-1:0]    key;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [1:0]          kind;
      logic [HANDLE_W-1:0] item_handle;
      logic [KEY_W-1:0]    item_key;
   } req_word_type;

   typedef struct packed {
      logic                found;
      logic                fresh_empty;
      logic [HANDLE_W-1:0] out_handle;
      logic [KEY_W-1:0]    out_key;
      logic [COUNT_W-1:0]  entry_count;
      logic                dropped;
   } rsp_word_type;

   typedef struct packed {
      logic         done;
      rsp_word_type word;
   } cmp_type;

endpackage

FILE: src/spq_if.sv
// Valid/ready channel interfaces for request and response words
interface spq_req_if;
   import spq_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface spq_rsp_if;
   import spq_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: src/spq_ram.sv
// Generic one-write one-read RAM with registered read data
module spq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/spq_ctrl.sv
// Sequencer that walks the slot memory for insert and remove
`include "assert_macros.svh"

module spq_ctrl #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  spq_pkg::req_word_type       req_word,
   output logic                        req_ready,
   input  logic                        rsp_free,
   output spq_pkg::cmp_type            cmp,
   output logic                        wr_en,
   output logic [$clog2(CAPACITY)-1:0] wr_addr,
   output spq_pkg::entry_type          wr_data,
   output logic [$clog2(CAPACITY)-1:0] rd_addr,
   input  spq_pkg::entry_type          rd_data
);
   import spq_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_PUSH      = 3'd1;
   localparam logic [2:0] S_INSERT    = 3'd2;
   localparam logic [2:0] S_POP_HEAD  = 3'd3;
   localparam logic [2:0] S_POP_SHIFT = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   entry_type        new_ff, new_in;
   entry_type        out_ff, out_in;

   logic [CNT_W-1:0] cnt_inc, cnt_dec, idx_ext_inc;
   logic [IDX_W-1:0] idx_inc, idx_dec, last_idx;
   logic             accept;

   assign cnt_inc     = count_ff + CNT_W'(1);
   assign cnt_dec     = count_ff - CNT_W'(1);
   assign idx_ext_inc = CNT_W'(idx_ff) + CNT_W'(1);
   assign idx_inc     = idx_ff + IDX_W'(1);
   assign idx_dec     = idx_ff - IDX_W'(1);
   assign last_idx    = cnt_dec[IDX_W-1:0];

   assign req_ready = (state_ff == S_IDLE) && rsp_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      logic        done;
      logic        res_found;
      logic        res_fresh;
      logic        res_drop;
      entry_type   res_entry;
      logic [31:0] cnt_wide;

      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      new_in    = new_ff;
      out_in    = out_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_inc;
      wr_data   = new_ff;
      rd_addr   = idx_ff;
      done      = 1'b0;
      res_found = 1'b0;
      res_fresh = 1'b0;
      res_drop  = 1'b0;
      res_entry = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               new_in.handle = req_word.item_handle;
               new_in.key    = req_word.item_key;
               unique case (req_word.kind)
                  KIND_PUSH: begin
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        done     = 1'b1;
                        res_drop = 1'b1;
                     end else if (count_ff == '0) begin
                        wr_en    = 1'b1;
                        wr_addr  = '0;
                        wr_data  = new_in;
                        count_in = cnt_inc;
                        done     = 1'b1;
                     end else begin
                        rd_addr  = last_idx;
                        idx_in   = last_idx;
                        state_in = S_PUSH;
                     end
                  end
                  KIND_POP_SECOND: begin
                     if (count_ff > CNT_W'(1)) begin
                        rd_addr  = IDX_W'(1);
                        idx_in   = IDX_W'(1);
                        state_in = S_POP_HEAD;
                     end else begin
                        done      = 1'b1;
                        res_fresh = 1'b1;
                     end
                  end
                  KIND_POP_FRONT: begin
                     if (count_ff != '0) begin
                        rd_addr  = '0;
                        idx_in   = '0;
                        state_in = S_POP_HEAD;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         S_PUSH: begin
            wr_en = 1'b1;
            if (rd_data.key < new_ff.key) begin
               wr_data = rd_data;
               if (idx_ff == '0) begin
                  state_in = S_INSERT;
               end else begin
                  rd_addr = idx_dec;
                  idx_in  = idx_dec;
               end
            end else begin
               count_in = cnt_inc;
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_INSERT: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            count_in = cnt_inc;
            done     = 1'b1;
            state_in = S_IDLE;
         end
         S_POP_HEAD: begin
            out_in = rd_data;
            if (idx_ext_inc < count_ff) begin
               rd_addr  = idx_inc;
               idx_in   = idx_inc;
               state_in = S_POP_SHIFT;
            end else begin
               count_in  = cnt_dec;
               done      = 1'b1;
               res_found = 1'b1;
               res_entry = rd_data;
               state_in  = S_IDLE;
            end
         end
         S_POP_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = idx_dec;
            wr_data = rd_data;
            if (idx_ext_inc < count_ff) begin
               rd_addr = idx_inc;
               idx_in  = idx_inc;
            end else begin
               count_in  = cnt_dec;
               done      = 1'b1;
               res_found = 1'b1;
               res_entry = out_ff;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      cnt_wide              = 32'(count_in);
      cmp.done              = done;
      cmp.word.found        = res_found;
      cmp.word.fresh_empty  = res_fresh;
      cmp.word.out_handle   = res_entry.handle;
      cmp.word.out_key      = res_entry.key;
      cmp.word.entry_count  = cnt_wide[COUNT_W-1:0];
      cmp.word.dropped      = res_drop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff <= idx_in;
      new_ff <= new_in;
      out_ff <= out_in;
   end

   `SPQ_ASSERT(count_in_range_a, clock, reset, count_ff <= CNT_W'(CAPACITY))
   `SPQ_ASSERT(walk_needs_entries_a, clock, reset, (state_ff != S_IDLE) |-> (count_ff != '0))
   `SPQ_ASSERT(drop_only_when_full_a, clock, reset, (cmp.done && cmp.word.dropped) |-> (count_ff == CNT_W'(CAPACITY)))

endmodule

FILE: src/sorted_priority_queue.sv
// Sorted priority queue top level: slot memory, sequencer, response register
//
//   channel   dir   handshake     word
//   req_chan  in    valid/ready   kind, item_handle, item_key
//   rsp_chan  out   valid/ready   found, fresh_empty, out_handle, out_key,
//                                 entry_count, dropped
//
// Push and pop walk the single-port-read slot memory entry by entry; refused
// and empty cases are answered from the idle state without a walk.
// One request is worked at a time; a new one is taken once the response
// register is empty or being drained. Reset empties the queue at once.
// A stalled response holds its register and blocks further requests.
`include "assert_macros.svh"

module sorted_priority_queue #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req_chan,
   spq_rsp_if.source rsp_chan
);
   import spq_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   entry_type        wr_data, rd_data;
   cmp_type          cmp;
   logic             rsp_free;

   logic             rsp_valid_ff;
   rsp_word_type     rsp_word_ff;

   spq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   spq_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_word  (req_chan.data),
      .req_ready (req_chan.ready),
      .rsp_free  (rsp_free),
      .cmp       (cmp),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmp.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmp.done) begin
         rsp_word_ff <= cmp.word;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_word_ff;

   `SPQ_ASSERT(no_overwrite_a, clock, reset, (rsp_valid_ff && !rsp_chan.ready) |-> !cmp.done)
   `SPQ_ASSERT(hold_word_a, clock, reset, (rsp_valid_ff && !rsp_chan.ready) |=> $stable(rsp_word_ff))
   `SPQ_ASSERT_ALWAYS(reset_empties_a, clock, reset |=> !rsp_valid_ff)

endmodule

FILE: tb/tb_top.sv
// Testbench top for sorted_priority_queue: directed and random request words checked in order
`timescale 1ns / 100ps

module tb_top;
   import spq_pkg::*;

   localparam int         QUEUE_DEPTH = CAPACITY_DEF;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset;

   spq_req_if req_if ();
   spq_rsp_if rsp_if ();

   sorted_priority_queue uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #2 clock = ~clock;

   logic [HANDLE_W-1:0] held_handle [QUEUE_DEPTH];
   logic [KEY_W-1:0]    held_key [QUEUE_DEPTH];
   int unsigned         held_total;

   rsp_word_type pending_rsp [$];
   int           fail_count;
   int           req_gap_on;
   int           rsp_stall_on;
   int           rsp_hold_cycles;
   int           stat_push, stat_drop, stat_pop, stat_fresh, stat_peak, stat_words;

   function automatic void drop_slot(int unsigned pos);
      for (int unsigned i = pos; i + 1 < held_total; i++) begin
         held_handle[i] = held_handle[i+1];
         held_key[i]    = held_key[i+1];
      end
      held_total--;
   endfunction

   function automatic rsp_word_type queue_step(req_word_type w);
      rsp_word_type r;
      int unsigned  pos;
      r = '0;
      stat_words++;
      case (w.kind)
         KIND_PUSH: begin
            if (held_total >= QUEUE_DEPTH) begin
               r.dropped = 1'b1;
               stat_drop++;
            end else begin
               pos = 0;
               while (pos < held_total && held_key[pos] >= w.item_key) pos++;
               for (int unsigned i = held_total; i > pos; i--) begin
                  held_handle[i] = held_handle[i-1];
                  held_key[i]    = held_key[i-1];
               end
               held_handle[pos] = w.item_handle;
               held_key[pos]    = w.item_key;
               held_total++;
               stat_push++;
               if (held_total > stat_peak) stat_peak = held_total;
            end
         end
         KIND_POP_SECOND: begin
            if (held_total > 1) begin
               r.found      = 1'b1;
               r.out_handle = held_handle[1];
               r.out_key    = held_key[1];
               drop_slot(1);
               stat_pop++;
            end else begin
               r.fresh_empty = 1'b1;
               stat_fresh++;
            end
         end
         KIND_POP_FRONT: begin
            if (held_total > 0) begin
               r.found      = 1'b1;
               r.out_handle = held_handle[0];
               r.out_key    = held_key[0];
               drop_slot(0);
               stat_pop++;
            end
         end
         default: ;
      endcase
      r.entry_count = COUNT_W'(held_total);
      return r;
   endfunction

   function automatic void note_failure(string what, rsp_word_type want, rsp_word_type got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t mismatch (%s): expected f=%0b fe=%0b h=%h k=%h n=%0d d=%0b",
                  $realtime, what, want.found, want.fresh_empty, want.out_handle, want.out_key,
                  want.entry_count, want.dropped);
         $display("   got f=%0b fe=%0b h=%h k=%h n=%0d d=%0b", got.found, got.fresh_empty,
                  got.out_handle, got.out_key, got.entry_count, got.dropped);
      end
   endfunction

   always @(posedge clock) begin
      rsp_word_type want, got;
      string        bad;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.data;
         bad = "";
         if (pending_rsp.size() == 0) begin
            note_failure("unexpected word", '0, got);
         end else begin
            want = pending_rsp[0];
            pending_rsp.delete(0);
            if (got.found !== want.found) bad = {bad, " found"};
            if (got.fresh_empty !== want.fresh_empty) bad = {bad, " fresh_empty"};
            if (got.out_handle !== want.out_handle) bad = {bad, " out_handle"};
            if (got.out_key !== want.out_key) bad = {bad, " out_key"};
            if (got.entry_count !== want.entry_count) bad = {bad, " entry_count"};
            if (got.dropped !== want.dropped) bad = {bad, " dropped"};
            if (bad != "") note_failure(bad, want, got);
         end
      end
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end else if (rsp_stall_on != 0 && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   task automatic send_word(input req_word_type w);
      if (req_gap_on != 0 && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= w;
      do @(posedge clock); while (!req_if.ready);
      pending_rsp.push_back(queue_step(w));
   endtask

   task automatic send_fields(input logic [1:0] kind, input logic [HANDLE_W-1:0] handle,
                              input logic [KEY_W-1:0] key);
      req_word_type w;
      w.kind        = kind;
      w.item_handle = handle;
      w.item_key    = key;
      send_word(w);
   endtask

   task automatic wait_drained;
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   function automatic req_word_type random_word(int push_pct);
      req_word_type w;
      int           roll;
      w.item_handle = HANDLE_W'($urandom);
      case ($urandom_range(0, 3))
         0:       w.item_key = KEY_W'($urandom_range(0, 7));
         1:       w.item_key = ($urandom_range(0, 1) != 0) ? '1 : '0;
         default: w.item_key = KEY_W'($urandom);
      endcase
      roll = $urandom_range(0, 99);
      if (roll < push_pct) w.kind = KIND_PUSH;
      else if (roll >= 95) w.kind = KIND_UNUSED;
      else if (roll % 2 == 0) w.kind = KIND_POP_FRONT;
      else w.kind = KIND_POP_SECOND;
      return w;
   endfunction

   task automatic test_basics;
      send_fields(KIND_POP_FRONT, 16'hFFFF, '1);
      send_fields(KIND_POP_SECOND, 16'hFFFF, '1);
      send_fields(KIND_UNUSED, 16'hFFFF, '1);
      send_fields(KIND_PUSH, 16'h0000, 32'h0000_0000);
      send_fields(KIND_POP_SECOND, 16'h0000, 32'h0);
      send_fields(KIND_PUSH, 16'hFFFF, 32'hFFFF_FFFF);
      send_fields(KIND_PUSH, 16'h1234, 32'hFFFF_FFFF);
      send_fields(KIND_PUSH, 16'h0001, 32'h0000_0005);
      send_fields(KIND_PUSH, 16'h0002, 32'h0000_0005);
      send_fields(KIND_UNUSED, 16'h5A5A, 32'hA5A5_A5A5);
      send_fields(KIND_POP_SECOND, 16'h0, 32'h0);
      send_fields(KIND_POP_FRONT, 16'h0, 32'h0);
      send_fields(KIND_POP_FRONT, 16'h0, 32'h0);
      send_fields(KIND_POP_FRONT, 16'h0, 32'h0);
      send_fields(KIND_POP_SECOND, 16'h0, 32'h0);
      send_fields(KIND_POP_FRONT, 16'h0, 32'h0);
      send_fields(KIND_POP_FRONT, 16'h0, 32'h0);
      wait_drained();
   endtask

   task automatic test_full;
      for (int i = 0; i < QUEUE_DEPTH; i++)
         send_fields(KIND_PUSH, HANDLE_W'(i + 1), KEY_W'($urandom_range(0, 3)));
      send_fields(KIND_PUSH, 16'hBEEF, 32'hFFFF_FFFF);
      send_fields(KIND_UNUSED, 16'h0, 32'h0);
      send_fields(KIND_POP_SECOND, 16'h0, 32'h0);
      send_fields(KIND_PUSH, 16'hCAFE, 32'h0000_0002);
      send_fields(KIND_PUSH, 16'hF00D, 32'h0000_0000);
      send_fields(KIND_POP_FRONT, 16'h0, 32'h0);
      wait_drained();
   endtask

   task automatic test_backpressure;
      req_gap_on      = 0;
      rsp_hold_cycles = 300;
      for (int i = 0; i < 24; i++) send_word(random_word(70));
      wait_drained();
   endtask

   task automatic test_random;
      int push_pct;
      for (int seg = 0; seg < 15; seg++) begin
         case (seg % 3)
            0:       push_pct = 75;
            1:       push_pct = 25;
            default: push_pct = $urandom_range(30, 70);
         endcase
         req_gap_on   = ($urandom_range(0, 3) != 0);
         rsp_stall_on = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < 50; i++) send_word(random_word(push_pct));
         if ($urandom_range(0, 2) == 0) wait_drained();
      end
      wait_drained();
   endtask

   task automatic test_no_idle;
      req_gap_on   = 0;
      rsp_stall_on = 0;
      for (int i = 0; i < 100; i++) send_word(random_word(50));
      wait_drained();
   endtask

   initial begin
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.data     = '0;
      held_total      = 0;
      fail_count      = 0;
      req_gap_on      = 1;
      rsp_stall_on    = 1;
      rsp_hold_cycles = 0;
      stat_push = 0; stat_drop = 0; stat_pop = 0; stat_fresh = 0; stat_peak = 0; stat_words = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basics();
      test_full();
      test_backpressure();
      test_random();
      test_no_idle();

      repeat (40) @(posedge clock);
      fail_count += pending_rsp.size();
      $display("%0d request words: %0d pushes stored, %0d refused as full, %0d entries popped",
               stat_words, stat_push, stat_drop, stat_pop);
      $display("%0d pop-second misses, peak depth %0d, %0d mismatches",
               stat_fresh, stat_peak, fail_count);
      if (fail_count == 0)
         $display("[sorted_priority_queue] OK");
      else
         $display("[sorted_priority_queue] ERROR");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("[sorted_priority_queue] ERROR");
      $finish;
   end

endmodule

FILE: sorted_priority_queue.f
+incdir+src
src/spq_pkg.sv
src/spq_if.sv
src/spq_ram.sv
src/spq_ctrl.sv
src/sorted_priority_queue.sv
tb/tb_top.sv
